@@ hdl/tfpma_pkg.sv @@
// ============================================================================
// tfpma_pkg
// Shared constants and types for the range frame parser with moving average.
// ============================================================================
`default_nettype none

package tfpma_pkg;

    // frame format
    localparam logic [7:0] HDR_BYTE   = 8'h57;
    localparam logic [7:0] MARK_BYTE  = 8'h00;
    localparam logic [3:0] FRAME_LAST = 4'd15;   // checksum byte position

    // field widths
    localparam int RAW_W = 24;
    localparam int AVG_W = 32;

    // averaging window, 1 to 64 samples
    localparam int AVG_DEPTH = 8;
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(AVG_DEPTH + 1);

    // running sum and Q.8 dividend
    localparam int SUM_W     = RAW_W + CNT_W;
    localparam int DVD_W     = SUM_W + 8;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // completed frame from the parser
    typedef struct packed {
        logic                    done;  // good frame ends on this item
        logic signed [RAW_W-1:0] raw;
    } frame_t;

endpackage

`default_nettype wire

@@ hdl/tof_frame_parser_moving_average.sv @@
// ============================================================================
// tof_frame_parser_moving_average
// Range sensor frame parser with a moving average over the last samples.
// ============================================================================
// After the checksum byte of a good frame the ring update (ST_SUM), the
//   bit-serial divider (ST_DIV) and the output register (ST_OUT) run in turn.
// Throughput: one byte per cycle inside a frame; after a good frame the input
//   stalls while the ring, the divider and the output register are in use.
// Reset: aresetn (synchronous, active low) clears the byte position, ring
//   slot, fill flag and running sum; ring contents are never cleared.
// ============================================================================
`default_nettype none

module tof_frame_parser_moving_average (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input item stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result item stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [31:0] distance_avg, [55:32] distance_raw
);
    import tfpma_pkg::*;

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking bytes
    localparam logic [1:0] ST_SUM  = 2'd1;  // old ring entry on read port
    localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
    localparam logic [1:0] ST_OUT  = 2'd3;  // wait for output register

    logic [1:0]               state_reg, state_next;
    logic [SLOT_W-1:0]        slot_reg,  slot_next;
    logic                     full_reg,  full_next;
    logic signed [SUM_W-1:0]  sum_reg,   sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [RAW_W-1:0]  raw_reg,   raw_next;
    logic                     div_start_reg, div_start_next;
    logic                     m_valid_reg, m_valid_next;
    logic [55:0]              m_data_reg,  m_data_next;

    logic                     s_accept;
    frame_t                   frame;
    logic [RAW_W-1:0]         ring_rdata;
    logic signed [RAW_W-1:0]  old_sample;
    logic                     slot_wrap;
    logic                     div_done;
    logic signed [AVG_W-1:0]  avg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    tfpma_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (s_accept),
        .byte_in (s_tdata),
        .frame   (frame)
    );

    // ring of samples: the slot about to be overwritten is read as the frame
    // ends, and the new sample written back in the next cycle (ST_SUM)
    tfpma_ram #(
        .WIDTH (RAW_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (state_reg == ST_SUM),
        .waddr (slot_reg),
        .wdata (raw_reg),
        .raddr (slot_reg),
        .rdata (ring_rdata)
    );

    tfpma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend ({sum_reg, 8'b0}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (avg)
    );

    // slot entry only holds a sample once the ring has wrapped
    assign old_sample = full_reg ? $signed(ring_rdata) : '0;
    assign slot_wrap  = (slot_reg == SLOT_W'(AVG_DEPTH - 1));

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        raw_next       = raw_reg;
        div_start_next = 1'b0;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (frame.done) begin
                    raw_next   = frame.raw;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // running sum: drop the overwritten sample, add the new one
                sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(raw_reg);
                if (slot_wrap) begin
                    slot_next = '0;
                    full_next = 1'b1;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
                count_next = (slot_wrap || full_reg) ? CNT_W'(AVG_DEPTH)
                                                     : CNT_W'(slot_reg) + 1'b1;
                div_start_next = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {raw_reg, avg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
        count_reg  <= count_next;
        raw_reg    <= raw_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> (count_reg != '0))
        else $error("divider started with zero count");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !m_valid_reg) |-> (state_reg == ST_OUT))
        else $error("result item loaded outside output state");

    a_no_byte_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |=> (state_reg == ST_DIV) && !s_tready)
        else $error("ring update did not hand over to divider");

endmodule

`default_nettype wire

@@ hdl/tfpma_ram.sv @@
// ============================================================================
// tfpma_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module tfpma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/tfpma_parser.sv @@
// ============================================================================
// tfpma_parser
// Header hunt, running checksum and distance capture over a 16-byte frame.
// ============================================================================
`default_nettype none

module tfpma_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             byte_en,
    input  wire logic [7:0]       byte_in,
    output tfpma_pkg::frame_t     frame
);
    import tfpma_pkg::*;

    logic [3:0]       pos_reg,  pos_next;
    logic [7:0]       csum_reg, csum_next;
    logic             mark_reg, mark_next;
    logic [RAW_W-1:0] dist_reg, dist_next;
    logic             take;

    // outside a frame only the header byte starts one
    assign take = byte_en && ((pos_reg != 4'd0) || (byte_in == HDR_BYTE));

    always_comb begin
        pos_next  = pos_reg;
        csum_next = csum_reg;
        mark_next = mark_reg;
        dist_next = dist_reg;
        if (take) begin
            pos_next  = pos_reg + 4'd1;
            csum_next = (pos_reg == 4'd0) ? byte_in : csum_reg + byte_in;
            case (pos_reg)
                4'd1:    mark_next = (byte_in == MARK_BYTE);
                4'd8:    dist_next[7:0]   = byte_in;
                4'd9:    dist_next[15:8]  = byte_in;
                4'd10:   dist_next[23:16] = byte_in;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
        end else begin
            pos_reg <= pos_next;
        end
        csum_reg <= csum_next;
        mark_reg <= mark_next;
        dist_reg <= dist_next;
    end

    assign frame.done = take && (pos_reg == FRAME_LAST) && mark_reg && (csum_reg == byte_in);
    assign frame.raw  = $signed(dist_reg);

endmodule

`default_nettype wire

@@ hdl/tfpma_div.sv @@
// ============================================================================
// tfpma_div
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// ============================================================================
`default_nettype none

module tfpma_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [tfpma_pkg::DVD_W-1:0]    dividend,
    input  wire logic        [tfpma_pkg::CNT_W-1:0]    divisor,
    output logic                                       done,
    output logic signed [tfpma_pkg::AVG_W-1:0]         quotient
);
    import tfpma_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DVD_W-1:0]     mag_reg,  mag_next;
    logic [CNT_W-1:0]     rem_reg,  rem_next;
    logic [CNT_W-1:0]     den_reg,  den_next;
    logic                 neg_reg,  neg_next;
    logic [CNT_W:0]       trial;
    logic                 ge;
    logic [DVD_W-1:0]     q_signed;

    assign trial = {rem_reg, mag_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DVD_W-1];
            mag_next  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            mag_next = {mag_reg[DVD_W-2:0], ge};
            rem_next = ge ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // quotient magnitude always fits the result width
    assign q_signed = neg_reg ? -mag_reg : mag_reg;
    assign quotient = $signed(q_signed[AVG_W-1:0]);
    assign done     = done_reg;

endmodule

`default_nettype wire

@@ test/range_avg_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// range_avg_checker
// Watches both streams of the range frame parser, predicts each result item
// from the accepted bytes and compares it field by field.
// ============================================================================
`default_nettype none

module range_avg_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,   // [31:0] distance_avg, [55:32] distance_raw
    output int               fail_count,
    output int               n_pending
);
    import tfpma_pkg::*;

    typedef struct packed {
        logic [AVG_W-1:0] avg;
        logic [RAW_W-1:0] raw;
    } range_result_t;

    range_result_t           pending_results[$];

    // predictor state
    logic [7:0]              frame_bytes [16];
    logic [3:0]              byte_pos;
    logic signed [RAW_W-1:0] sample_ring [AVG_DEPTH];
    int                      ring_slot;
    bit                      ring_full;
    int                      fails = 0;

    // Absorb one accepted byte; queue the filtered distance when a good frame ends.
    task automatic take_byte(input logic [7:0] b);
        logic [7:0]              sum;
        logic signed [RAW_W-1:0] dist_val;
        longint                  acc;
        longint                  mean;
        int                      count;
        int                      i;
        range_result_t           r;
        if (byte_pos == 0 && b != HDR_BYTE)
            return;
        frame_bytes[byte_pos] = b;
        if (byte_pos != FRAME_LAST) begin
            byte_pos = byte_pos + 4'd1;
            return;
        end
        byte_pos = 0;
        sum = 8'd0;
        for (i = 0; i < FRAME_LAST; i++)
            sum = sum + frame_bytes[i];
        // bad mark or checksum: drop, no rescan of the payload
        if (frame_bytes[1] != MARK_BYTE || sum != frame_bytes[FRAME_LAST])
            return;
        dist_val = {frame_bytes[10], frame_bytes[9], frame_bytes[8]};
        sample_ring[ring_slot] = dist_val;
        ring_slot++;
        if (ring_slot == AVG_DEPTH) begin
            ring_slot = 0;
            ring_full = 1'b1;
        end
        count = ring_full ? AVG_DEPTH : ring_slot;
        acc = 0;
        for (i = 0; i < count; i++)
            acc += sample_ring[i];
        mean = (acc * 256) / count;   // signed, truncates toward zero
        r.avg = mean[AVG_W-1:0];
        r.raw = dist_val;
        pending_results.push_back(r);
    endtask

    always @(posedge aclk) begin : watch
        range_result_t want;
        logic [AVG_W-1:0] got_avg;
        logic [RAW_W-1:0] got_raw;
        bit bad;
        if (!aresetn) begin
            byte_pos  = 0;
            ring_slot = 0;
            ring_full = 1'b0;
            pending_results.delete();
        end else begin
            // results first: an item accepted on this edge cannot have caused one yet
            if (m_tvalid && m_tready) begin
                got_avg = m_tdata[AVG_W-1:0];
                got_raw = m_tdata[AVG_W+RAW_W-1:AVG_W];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item: avg %0d raw %0d", $time,
                             $signed(got_avg), $signed(got_raw));
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    bad = 1'b0;
                    if (got_avg !== want.avg) begin
                        $display("%0t: distance_avg mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.avg), $signed(got_avg));
                        bad = 1'b1;
                    end
                    if (got_raw !== want.raw) begin
                        $display("%0t: distance_raw mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.raw), $signed(got_raw));
                        bad = 1'b1;
                    end
                    if (bad)
                        fails++;
                end
            end
            if (s_tvalid && s_tready)
                take_byte(s_tdata);
        end
        fail_count <= fails;
        n_pending  <= pending_results.size();
    end

endmodule

`default_nettype wire

@@ test/tb_tof_frame_parser_moving_average.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_tof_frame_parser_moving_average
// Drives framed and broken byte streams into the range parser under several
// idle/stall mixes; a checker beside the block predicts and compares results.
// ============================================================================
`default_nettype none

module tb_tof_frame_parser_moving_average;
    import tfpma_pkg::*;

    localparam int TOTAL_BYTES = 1500;
    localparam int STALL_LIMIT = 5000;   // cycles with no item moving on either side
    localparam int TAIL_CYCLES = DVD_W + 20;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_MARK,
        FRAME_BAD_SUM,
        FRAME_CUT
    } frame_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [31:0] distance_avg, [55:32] distance_raw

    int fail_count;
    int n_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int idle_cycles    = 0;
    int streak_left    = 0;
    logic [23:0] streak_dist;

    tof_frame_parser_moving_average uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    range_avg_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .n_pending  (n_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle at the falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog: no item moving for too long means the block hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One byte: optional sender gaps, then hold valid until the handshake.
    // Called at a falling edge and returns at a falling edge.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        bytes_sent++;
    endtask

    // Payload bytes carry a stray header now and then; it must not resync.
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(0, 7) == 0)
            return HDR_BYTE;
        return 8'($urandom);
    endfunction

    // Distance mix: extremes, zero and -1 often, otherwise any 24-bit value.
    function automatic logic [23:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Build a 16-byte frame with the given distance, optionally corrupted
    // (bad mark, bad checksum) or cut short so the next bytes fill it up.
    task automatic send_frame(input frame_kind_t kind, input logic [23:0] dist_val);
        logic [7:0] fb [16];
        logic [7:0] sum;
        int         i;
        int         cut;
        fb[0] = HDR_BYTE;
        fb[1] = MARK_BYTE;
        for (i = 2; i < 15; i++)
            fb[i] = payload_byte();
        fb[8]  = dist_val[7:0];
        fb[9]  = dist_val[15:8];
        fb[10] = dist_val[23:16];
        if (kind == FRAME_BAD_MARK)
            fb[1] = 8'($urandom_range(1, 255));
        sum = 8'd0;
        for (i = 0; i < 15; i++)
            sum = sum + fb[i];
        fb[15] = sum;
        if (kind == FRAME_BAD_SUM)
            fb[15] = sum ^ 8'($urandom_range(1, 255));
        cut = (kind == FRAME_CUT) ? $urandom_range(1, 15) : 16;
        for (i = 0; i < cut; i++)
            push_byte(fb[i]);
    endtask

    // Random traffic until the byte budget of this phase is used up.
    // Mostly good frames; streaks of one extreme push the average to its rails.
    task automatic random_traffic(input int upto);
        int          pick;
        logic [23:0] dist_val;
        while (bytes_sent < upto) begin
            pick = $urandom_range(0, 99);
            if (streak_left > 0) begin
                dist_val = streak_dist;
                streak_left--;
            end else begin
                dist_val = pick_distance();
                if ($urandom_range(0, 19) == 0) begin
                    streak_left = AVG_DEPTH + 1;
                    streak_dist = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                end
            end
            if (pick < 10)
                push_byte(8'($urandom));
            else if (pick < 16)
                send_frame(FRAME_BAD_MARK, dist_val);
            else if (pick < 22)
                send_frame(FRAME_BAD_SUM, dist_val);
            else if (pick < 28)
                send_frame(FRAME_CUT, dist_val);
            else
                send_frame(FRAME_GOOD, dist_val);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: header hunt drops non-header bytes (neighbors of the header
        // included), then a good frame with the most negative distance fills
        // the first ring slot.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(HDR_BYTE - 8'd1);
        push_byte(HDR_BYTE + 8'd1);
        send_frame(FRAME_GOOD, 24'h800000);

        // Phases: free-running, slow sender, slow receiver, both a little slow.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(TOTAL_BYTES / 4);
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        random_traffic(TOTAL_BYTES / 2);
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        random_traffic(3 * TOTAL_BYTES / 4);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        random_traffic(TOTAL_BYTES);
        s_tvalid <= 1'b0;

        // Drain: every predicted result out, then room for a late extra one.
        while (n_pending != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && n_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/tfpma_pkg.sv
hdl/tfpma_ram.sv
hdl/tfpma_parser.sv
hdl/tfpma_div.sv
hdl/tof_frame_parser_moving_average.sv
test/range_avg_checker.sv
test/tb_tof_frame_parser_moving_average.sv
